// ===== hdl/pcs_pkg.sv =====
`timescale 1ns / 1ps

package pcs_pkg;

    typedef enum logic [1:0] {
        CMD_PRESS   = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_TICK    = 2'd2,
        CMD_START   = 2'd3
    } cmd_t;

    localparam logic [2:0] BTN_UP    = 3'd0;
    localparam logic [2:0] BTN_RIGHT = 3'd1;
    localparam logic [2:0] BTN_DOWN  = 3'd2;
    localparam logic [2:0] BTN_LEFT  = 3'd3;

    typedef enum logic [2:0] {
        REG_VIEW_WIDTH  = 3'd0,
        REG_VIEW_HEIGHT = 3'd1,
        REG_MAP_WIDTH   = 3'd2,
        REG_MAP_HEIGHT  = 3'd3,
        REG_START_X     = 3'd4,
        REG_START_Y     = 3'd5
    } cfg_reg_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 15;
    localparam int VIEW_W      = 12;
    localparam int MAP_W       = 15;

    localparam logic [VIEW_W-1:0] VIEW_WIDTH_RST  = 12'd640;
    localparam logic [VIEW_W-1:0] VIEW_HEIGHT_RST = 12'd480;
    localparam logic [MAP_W-1:0]  MAP_WIDTH_RST   = 15'd1024;
    localparam logic [MAP_W-1:0]  MAP_HEIGHT_RST  = 15'd1024;

    localparam int MARGIN_PX = 80;
    localparam int SPRITE_PX = 48;

    // floor(ms / 10) == (ms * 52429) >> 19 for every 16-bit ms
    localparam logic [16:0] DIV10_MUL   = 17'd52429;
    localparam int          DIV10_SHIFT = 19;
    localparam int          DELTA_W     = 13;

    typedef struct packed {
        cmd_t        cmd;
        logic [2:0]  key;
        logic [15:0] elapsed_ms;
    } pcs_item_t;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] cam_x;
        logic signed [15:0] cam_y;
        logic [2:0]         facing;
        logic [3:0]         dir_mask;
    } pcs_result_t;

    // facing code from held direction mask; unlisted masks face 0
    function automatic logic [2:0] facing_lookup(input logic [3:0] mask);
        logic [2:0] code;
        case (mask)
            4'h1:    code = 3'd0;
            4'h2:    code = 3'd2;
            4'h3:    code = 3'd1;
            4'h4:    code = 3'd4;
            4'h6:    code = 3'd3;
            4'h8:    code = 3'd6;
            4'h9:    code = 3'd7;
            4'hC:    code = 3'd5;
            default: code = 3'd0;
        endcase
        return code;
    endfunction

endpackage

// ===== hdl/pcs_item_if.sv =====
`timescale 1ns / 1ps

interface pcs_item_if import pcs_pkg::*; ();
    logic      valid;
    logic      ready;
    pcs_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/pcs_result_if.sv =====
`timescale 1ns / 1ps

interface pcs_result_if import pcs_pkg::*; ();
    logic        valid;
    logic        ready;
    pcs_result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/player_camera_scroll.sv =====
`timescale 1ns / 1ps

// channel   dir   payload                                      transaction
// item      in    cmd, key, elapsed_ms                         valid & ready
// result    out   pos_x, pos_y, cam_x, cam_y, facing, dir_mask valid & ready
// cfg       in    cfg_index, cfg_data                          cfg_we
//
// One item per cycle unless stalled; result valid the next cycle. The state
// registers double as the result register, so the next item is taken in
// the same cycle the pending result is taken. The tick path (divide by ten
// through a 16x17 multiply, then add, compare and clamp) sets the cycle time.
// rst_n clears the position, camera, mask and facing and loads the register
// defaults. A stalled result holds item.ready low.

module player_camera_scroll
    import pcs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    pcs_item_if.sink               item,
    pcs_result_if.source           result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CW = 20;
    localparam logic signed [CW-1:0] MARGIN     = CW'(MARGIN_PX);
    localparam logic signed [CW-1:0] MARGIN2    = CW'(2 * MARGIN_PX);
    localparam logic signed [CW-1:0] SPRITE     = CW'(SPRITE_PX);
    localparam logic signed [CW-1:0] ZERO       = '0;

    typedef struct packed {
        logic signed [15:0] pos;
        logic signed [15:0] cam;
    } axis_t;

    logic [VIEW_W-1:0] view_w_reg, view_h_reg;
    logic [MAP_W-1:0]  map_w_reg, map_h_reg, start_x_reg, start_y_reg;

    logic [3:0]         held_reg, held_next;
    logic [2:0]         facing_reg, facing_next;
    logic signed [15:0] pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic signed [15:0] cam_x_reg, cam_x_next, cam_y_reg, cam_y_next;
    logic               vld_reg;

    logic               accept;
    logic [3:0]         key_bit;
    logic [32:0]        div_prod;
    logic [DELTA_W-1:0] delta;
    axis_t              move_x, move_y, ctr_x, ctr_y;

    function automatic axis_t move_axis(
        input logic signed [15:0] pos,
        input logic signed [15:0] cam,
        input logic               fwd,
        input logic               back,
        input logic [DELTA_W-1:0] delta_px,
        input logic [VIEW_W-1:0]  view,
        input logic [MAP_W-1:0]   map
    );
        logic signed [CW-1:0] p, c, v, m, d, lo_edge, hi_edge, lim;
        axis_t r;
        p = {{(CW-16){pos[15]}}, pos};
        c = {{(CW-16){cam[15]}}, cam};
        v = {{(CW-VIEW_W){1'b0}}, view};
        m = {{(CW-MAP_W){1'b0}}, map};
        d = {{(CW-DELTA_W){1'b0}}, delta_px};
        lo_edge = c + MARGIN;
        hi_edge = lo_edge + v - MARGIN2;
        lim     = m - v;
        if (fwd)
        begin
            p = p + d;
            if (p > hi_edge)
            begin
                c = p - v + MARGIN;
                if (c >= lim)
                    c = lim;
            end
            if (p > m - SPRITE)
                p = m - SPRITE;
        end
        else if (back)
        begin
            p = p - d;
            if (p < lo_edge)
            begin
                c = p - MARGIN;
                if (c < ZERO)
                    c = ZERO;
            end
            if (p < ZERO)
                p = ZERO;
        end
        r.pos = p[15:0];
        r.cam = c[15:0];
        return r;
    endfunction

    function automatic axis_t center_axis(
        input logic [MAP_W-1:0]  start,
        input logic [VIEW_W-1:0] view,
        input logic [MAP_W-1:0]  map
    );
        logic signed [CW-1:0] p, c, half, lim;
        axis_t r;
        p    = {{(CW-MAP_W){1'b0}}, start};
        half = {{(CW-VIEW_W+1){1'b0}}, view[VIEW_W-1:1]};
        lim  = {{(CW-MAP_W){1'b0}}, map} - {{(CW-VIEW_W){1'b0}}, view};
        c    = p - half;
        if (c < ZERO)
            c = ZERO;
        else if (c > lim)
            c = lim;
        r.pos = p[15:0];
        r.cam = c[15:0];
        return r;
    endfunction

    assign accept     = item.valid && item.ready;
    assign item.ready = !vld_reg || result.ready;

    assign key_bit  = (item.data.key <= BTN_LEFT) ? 4'(4'b0001 << item.data.key[1:0])
                                                  : 4'b0000;
    assign div_prod = {17'd0, item.data.elapsed_ms} * {16'd0, DIV10_MUL};
    assign delta    = div_prod[DIV10_SHIFT+DELTA_W-1:DIV10_SHIFT];

    // right beats left, down beats up
    assign move_x = move_axis(pos_x_reg, cam_x_reg, held_reg[1], !held_reg[1] && held_reg[3],
                              delta, view_w_reg, map_w_reg);
    assign move_y = move_axis(pos_y_reg, cam_y_reg, held_reg[2], !held_reg[2] && held_reg[0],
                              delta, view_h_reg, map_h_reg);
    assign ctr_x  = center_axis(start_x_reg, view_w_reg, map_w_reg);
    assign ctr_y  = center_axis(start_y_reg, view_h_reg, map_h_reg);

    always_comb
    begin
        held_next   = held_reg;
        facing_next = facing_reg;
        pos_x_next  = pos_x_reg;
        pos_y_next  = pos_y_reg;
        cam_x_next  = cam_x_reg;
        cam_y_next  = cam_y_reg;
        case (item.data.cmd)
            CMD_PRESS:
            begin
                held_next   = held_reg | key_bit;
                facing_next = facing_lookup(held_reg | key_bit);
            end
            CMD_RELEASE:
            begin
                held_next = held_reg & ~key_bit;
            end
            CMD_TICK:
            begin
                pos_x_next = move_x.pos;
                cam_x_next = move_x.cam;
                pos_y_next = move_y.pos;
                cam_y_next = move_y.cam;
            end
            CMD_START:
            begin
                pos_x_next = ctr_x.pos;
                cam_x_next = ctr_x.cam;
                pos_y_next = ctr_y.pos;
                cam_y_next = ctr_y.cam;
            end
            default:
            begin
                held_next = held_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_w_reg  <= VIEW_WIDTH_RST;
            view_h_reg  <= VIEW_HEIGHT_RST;
            map_w_reg   <= MAP_WIDTH_RST;
            map_h_reg   <= MAP_HEIGHT_RST;
            start_x_reg <= '0;
            start_y_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_VIEW_WIDTH:  view_w_reg  <= cfg_data[VIEW_W-1:0];
                REG_VIEW_HEIGHT: view_h_reg  <= cfg_data[VIEW_W-1:0];
                REG_MAP_WIDTH:   map_w_reg   <= cfg_data[MAP_W-1:0];
                REG_MAP_HEIGHT:  map_h_reg   <= cfg_data[MAP_W-1:0];
                REG_START_X:     start_x_reg <= cfg_data[MAP_W-1:0];
                REG_START_Y:     start_y_reg <= cfg_data[MAP_W-1:0];
                default:         view_w_reg  <= view_w_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg   <= '0;
            facing_reg <= '0;
            pos_x_reg  <= '0;
            pos_y_reg  <= '0;
            cam_x_reg  <= '0;
            cam_y_reg  <= '0;
            vld_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                held_reg   <= held_next;
                facing_reg <= facing_next;
                pos_x_reg  <= pos_x_next;
                pos_y_reg  <= pos_y_next;
                cam_x_reg  <= cam_x_next;
                cam_y_reg  <= cam_y_next;
                vld_reg    <= 1'b1;
            end
            else if (result.ready)
            begin
                vld_reg <= 1'b0;
            end
        end
    end

    assign result.valid         = vld_reg;
    assign result.data.pos_x    = pos_x_reg;
    assign result.data.pos_y    = pos_y_reg;
    assign result.data.cam_x    = cam_x_reg;
    assign result.data.cam_y    = cam_y_reg;
    assign result.data.facing   = facing_reg;
    assign result.data.dir_mask = held_reg;

`ifndef SYNTH
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result.valid)
        else $error("accepted transaction produced no result");

    a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.data.cmd == CMD_RELEASE |=> (held_reg & $past(key_bit)) == 4'b0000)
        else $error("released direction still held");

    a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.data.cmd == CMD_TICK && held_reg == 4'b0000
        |=> $stable(pos_x_reg) && $stable(pos_y_reg) && $stable(cam_x_reg)
            && $stable(cam_y_reg))
        else $error("tick with no held direction moved player or view");

    a_press_facing: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.data.cmd == CMD_PRESS |=> facing_reg == facing_lookup(held_reg))
        else $error("facing does not match held mask after press");
`endif

endmodule
